[design/hkr_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_pkg: shared types and constants for the hashed key range value block
// FNV-1a constants, the job record passed from front to back, and the
// back-end state encoding.
// ----------------------------------------------------------------------------
package hkr_pkg;

    localparam int HASH_W = 32;
    localparam int STEP_W = $clog2(HASH_W);

    localparam logic [HASH_W-1:0] FNV_BASIS = 32'd2166136261;
    localparam logic [HASH_W-1:0] FNV_PRIME = 32'd16777619;

    localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HASH_W - 1);

    // One finished key waiting for its range reduction
    typedef struct packed {
        logic [HASH_W-1:0] hash;
        logic [HASH_W-1:0] range_min;
        logic [HASH_W-1:0] range_max;
    } hkr_job_t;

    typedef enum logic [1:0] {
        HKR_IDLE,
        HKR_DIV,
        HKR_ADD,
        HKR_DONE
    } hkr_state_t;

    // One FNV-1a step: xor the byte in, multiply by the prime mod 2^32
    function automatic logic [HASH_W-1:0] hkr_fold(
        input logic [HASH_W-1:0] h,
        input logic [7:0]        b
    );
        logic [HASH_W-1:0] x;
        x = h ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage
`default_nettype wire

[design/hkr_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_front: key byte intake and FNV-1a folding
// Folds one byte per beat into the running hash if has_byte is set; on
// a key's last beat it hands the final hash and range bounds to the job queue.
// ----------------------------------------------------------------------------
module hkr_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire logic [7:0]                key_byte,
    input  wire logic                      has_byte,
    input  wire logic                      last_byte,
    input  wire logic [31:0]               range_min,
    input  wire logic [31:0]               range_max,
    output logic                           job_push,
    output hkr_pkg::hkr_job_t              job,
    input  wire logic                      q_full
);
    import hkr_pkg::*;

    logic [HASH_W-1:0] running_hash_reg;
    logic [HASH_W-1:0] running_hash_next;
    logic [HASH_W-1:0] folded;
    logic              accept;

    // Intake stalls only when the job queue cannot take a finished key
    assign full   = q_full;
    assign accept = push && !q_full;

    assign folded = has_byte ? hkr_fold(running_hash_reg, key_byte) : running_hash_reg;

    // Hash update: restart at the basis after the last byte
    always_comb
    begin
        running_hash_next = running_hash_reg;
        if (accept)
        begin
            running_hash_next = last_byte ? FNV_BASIS : folded;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_hash_reg <= FNV_BASIS;
        end
        else
        begin
            running_hash_reg <= running_hash_next;
        end
    end

    // Job handed to the back end
    assign job_push        = accept && last_byte;
    assign job.hash        = folded;
    assign job.range_min   = range_min;
    assign job.range_max   = range_max;

endmodule
`default_nettype wire

[design/hkr_queue.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_queue: job queue between front and back
// Small register queue of finished keys; lets the front keep taking bytes
// while the back end works through a range reduction.
// ----------------------------------------------------------------------------
module hkr_queue #(
    parameter int DEPTH = 2
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              wr_en,
    input  wire hkr_pkg::hkr_job_t wr_job,
    output logic                   q_full,
    input  wire logic              rd_en,
    output hkr_pkg::hkr_job_t      rd_job,
    output logic                   q_empty
);
    import hkr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    hkr_job_t          entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_full  = (count_reg == CNT_FULL);
    assign q_empty = (count_reg == '0);
    assign rd_job  = entries_reg[rd_ptr_reg];

    // Pointer and fill count update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (wr_en)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (rd_en)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (wr_en && !rd_en)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (rd_en && !wr_en)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage, no reset needed
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            entries_reg[wr_ptr_reg] <= wr_job;
        end
    end

    // Checks
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(wr_en && q_full))
        else $error("job written into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(rd_en && q_empty))
        else $error("job read from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue fill count beyond depth");

endmodule
`default_nettype wire

[design/hkr_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hkr_back: range reduction and result register
// Takes one job at a time, reduces the hash into [range_min, range_max]
// with a restoring divider (one quotient bit per cycle), and holds the
// result in an output register until it is popped.
// ----------------------------------------------------------------------------
module hkr_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire hkr_pkg::hkr_job_t rd_job,
    input  wire logic              q_empty,
    output logic                   rd_en,
    output logic                   empty,
    input  wire logic              pop,
    output logic [31:0]            ranged_value,
    output logic [31:0]            key_hash
);
    import hkr_pkg::*;

    hkr_state_t         state_reg, state_next;
    logic [HASH_W-1:0]  hash_reg, hash_next;
    logic [HASH_W-1:0]  min_reg, min_next;
    logic [HASH_W-1:0]  span_reg, span_next;
    logic [HASH_W-1:0]  dvd_reg, dvd_next;
    logic [HASH_W-1:0]  rem_reg, rem_next;
    logic [HASH_W-1:0]  value_reg, value_next;
    logic [STEP_W-1:0]  step_cnt_reg, step_cnt_next;
    logic               out_valid_reg, out_valid_next;
    logic [HASH_W-1:0]  ranged_value_reg;
    logic [HASH_W-1:0]  key_hash_reg;

    logic [HASH_W-1:0]  job_span;
    logic               job_empty_range;
    logic [HASH_W:0]    shifted;
    logic               sub_ok;
    logic               out_load;

    assign job_span        = rd_job.range_max - rd_job.range_min + 1'b1;
    assign job_empty_range = (rd_job.range_min >= rd_job.range_max);

    // One restoring divide step
    assign shifted = {rem_reg, dvd_reg[HASH_W-1]};
    assign sub_ok  = (shifted >= {1'b0, span_reg});

    // Next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            HKR_IDLE:
            begin
                if (!q_empty)
                begin
                    state_next = (job_empty_range || job_span == '0) ? HKR_DONE : HKR_DIV;
                end
            end
            HKR_DIV:
            begin
                if (step_cnt_reg == LAST_STEP)
                begin
                    state_next = HKR_ADD;
                end
            end
            HKR_ADD:
            begin
                state_next = HKR_DONE;
            end
            HKR_DONE:
            begin
                if (!out_valid_reg || pop)
                begin
                    state_next = HKR_IDLE;
                end
            end
            default:
            begin
                state_next = HKR_IDLE;
            end
        endcase
    end

    // State outputs
    always_comb
    begin
        rd_en    = 1'b0;
        out_load = 1'b0;
        case (state_reg)
            HKR_IDLE: rd_en    = !q_empty;
            HKR_DONE: out_load = !out_valid_reg || pop;
            default:
            begin
                rd_en    = 1'b0;
                out_load = 1'b0;
            end
        endcase
    end

    // Datapath next values
    always_comb
    begin
        hash_next     = hash_reg;
        min_next      = min_reg;
        span_next     = span_reg;
        dvd_next      = dvd_reg;
        rem_next      = rem_reg;
        value_next    = value_reg;
        step_cnt_next = step_cnt_reg;
        case (state_reg)
            HKR_IDLE:
            begin
                hash_next     = rd_job.hash;
                min_next      = rd_job.range_min;
                span_next     = job_span;
                dvd_next      = rd_job.hash;
                rem_next      = '0;
                step_cnt_next = '0;
                // empty range gives the minimum, full range gives the hash
                value_next    = job_empty_range ? rd_job.range_min : rd_job.hash;
            end
            HKR_DIV:
            begin
                dvd_next      = {dvd_reg[HASH_W-2:0], 1'b0};
                rem_next      = sub_ok ? HASH_W'(shifted - {1'b0, span_reg})
                                       : shifted[HASH_W-1:0];
                step_cnt_next = step_cnt_reg + 1'b1;
            end
            HKR_ADD:
            begin
                value_next = min_reg + rem_reg;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    // Result register valid flag
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (pop && out_valid_reg)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= HKR_IDLE;
            out_valid_reg <= 1'b0;
            step_cnt_reg  <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            step_cnt_reg  <= step_cnt_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        hash_reg  <= hash_next;
        min_reg   <= min_next;
        span_reg  <= span_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        value_reg <= value_next;
        if (out_load)
        begin
            ranged_value_reg <= value_reg;
            key_hash_reg     <= hash_reg;
        end
    end

    assign empty        = !out_valid_reg;
    assign ranged_value = ranged_value_reg;
    assign key_hash     = key_hash_reg;

    // Checks
    a_rem_below_span: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HKR_DIV) |-> (rem_reg < span_reg))
        else $error("divider remainder not below span");

    a_div_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HKR_DIV && step_cnt_reg == LAST_STEP) |=> (state_reg == HKR_ADD))
        else $error("divider did not finish after the last step");

    a_done_waits: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == HKR_DONE && out_valid_reg && !pop) |=> (state_reg == HKR_DONE))
        else $error("result left while the output register was occupied");

    a_take_only_idle: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (state_reg == HKR_IDLE))
        else $error("job taken while busy");

endmodule
`default_nettype wire

[design/hashed_key_range_value.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// hashed_key_range_value: FNV-1a key hash mapped into an inclusive range
// Folds key bytes into a 32-bit FNV-1a hash and, at the end of each key,
// reduces the hash into [range_min, range_max].
// ----------------------------------------------------------------------------
//  channel   handshake        payload
//  input     push / full      key_byte, has_byte, last_byte, range_min, range_max
//  result    empty / pop      ranged_value, key_hash
//
//  Key bytes are taken one beat per cycle while full is low; the hash fold
//  is combinational. A key end reaches the result ports through the queue
//  write, the take, 32 restoring divide steps, the add and the hand-off;
//  empty and full ranges skip the divider and the add.
//  Up to QUEUE_DEPTH finished keys wait between front and back; full rises
//  when that queue is full. Reset clears the hash to the offset basis.
// ----------------------------------------------------------------------------
module hashed_key_range_value #(
    parameter int QUEUE_DEPTH = 2
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push,
    output logic              full,
    input  wire logic [7:0]   key_byte,
    input  wire logic         has_byte,
    input  wire logic         last_byte,
    input  wire logic [31:0]  range_min,
    input  wire logic [31:0]  range_max,
    output logic              empty,
    input  wire logic         pop,
    output logic [31:0]       ranged_value,
    output logic [31:0]       key_hash
);
    import hkr_pkg::*;

    hkr_job_t  wr_job;
    hkr_job_t  rd_job;
    logic      job_push;
    logic      q_full;
    logic      q_empty;
    logic      rd_en;

    // Byte intake and hashing
    hkr_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .key_byte  (key_byte),
        .has_byte  (has_byte),
        .last_byte (last_byte),
        .range_min (range_min),
        .range_max (range_max),
        .job_push  (job_push),
        .job       (wr_job),
        .q_full    (q_full)
    );

    // Finished keys in flight
    hkr_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_push),
        .wr_job  (wr_job),
        .q_full  (q_full),
        .rd_en   (rd_en),
        .rd_job  (rd_job),
        .q_empty (q_empty)
    );

    // Range reduction and result register
    hkr_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .rd_job       (rd_job),
        .q_empty      (q_empty),
        .rd_en        (rd_en),
        .empty        (empty),
        .pop          (pop),
        .ranged_value (ranged_value),
        .key_hash     (key_hash)
    );

endmodule
`default_nettype wire
